// ===== rtl/core/integer_calculator_alu_core_assert.svh =====
// integer_calculator_alu_core_assert.svh: assertion macros for the integer ALU core.
// Needs nothing else; included by integer_calculator_alu_core.sv.
`ifndef INTEGER_CALCULATOR_ALU_CORE_ASSERT_SVH
`define INTEGER_CALCULATOR_ALU_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ICA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("integer ALU core assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ICA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("integer ALU core assertion failed");

`endif

// ===== rtl/core/ica_pkg.sv =====
// ica_pkg: opcodes, status codes, result type and saturation helpers of the integer ALU.
// Depends on nothing; used by integer_calculator_alu_core.
package ica_pkg;

   localparam logic [3:0] FUNC_ADD  = 4'd1;
   localparam logic [3:0] FUNC_SUB  = 4'd2;
   localparam logic [3:0] FUNC_MUL  = 4'd3;
   localparam logic [3:0] FUNC_DIV  = 4'd4;
   localparam logic [3:0] FUNC_POW  = 4'd5;
   localparam logic [3:0] FUNC_SQRT = 4'd6;
   localparam logic [3:0] FUNC_ABS  = 4'd7;

   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_ERR = 2'd1;
   localparam logic [1:0] STATUS_OVF = 2'd2;
   localparam logic [1:0] STATUS_INV = 2'd3;

   localparam logic [31:0] MAX_POS    = 32'h7FFF_FFFF;
   localparam logic [31:0] MIN_NEG    = 32'h8000_0000;
   localparam logic [31:0] POW_CAP    = 32'h8000_0001;
   localparam logic [31:0] SQRT_FIRST = 32'h4000_0000;

   typedef struct packed {
      logic [31:0] result;
      logic [1:0]  status;
   } alu_out_type;

   // Saturate a 33-bit two's complement value to 32 bits.
   function automatic alu_out_type sat33(input logic [32:0] v);
      alu_out_type o;
      o.result = v[31:0];
      o.status = STATUS_OK;
      if (!v[32] && v[31]) begin
         o.result = MAX_POS;
         o.status = STATUS_OVF;
      end else if (v[32] && !v[31]) begin
         o.result = MIN_NEG;
         o.status = STATUS_OVF;
      end
      return o;
   endfunction

   // Apply a sign to an unsigned magnitude and saturate to 32 bits.
   function automatic alu_out_type sat_mag(input logic neg, input logic [63:0] mag);
      alu_out_type o;
      o.status = STATUS_OK;
      if (neg) begin
         if (mag > {32'd0, MIN_NEG}) begin
            o.result = MIN_NEG;
            o.status = STATUS_OVF;
         end else begin
            o.result = 32'd0 - mag[31:0];
         end
      end else begin
         if (mag > {32'd0, MAX_POS}) begin
            o.result = MAX_POS;
            o.status = STATUS_OVF;
         end else begin
            o.result = mag[31:0];
         end
      end
      return o;
   endfunction

   // Clamp a power product to a value above both result limits.
   function automatic logic [31:0] pow_cap(input logic [63:0] p);
      logic [31:0] c;
      c = (p > {32'd0, POW_CAP}) ? POW_CAP : p[31:0];
      return c;
   endfunction

endpackage

// ===== rtl/core/integer_calculator_alu_core.sv =====
// integer_calculator_alu_core: add, sub, mul, div, pow, sqrt, abs on signed 32-bit operands.
// Add, sub, abs, error cases, invalid codes: strobe in the cycle after start, busy stays low.
// Multiply: state S_MUL through the 32x32 multiplier, then the registered strobe. Divide:
// one quotient bit per cycle on the shared subtractor, then S_FIN. Square root: S_SQRT, then S_FIN.
// Power: one multiplier pass per set exponent bit and per squaring, then S_FIN.
// One transaction at a time; sync reset clears the sequencer, strobe and last result.
module integer_calculator_alu_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_func,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_result,
   output logic [1:0]         rsp_status
);

`include "integer_calculator_alu_core_assert.svh"

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_SQRT  = 3'd3;
   localparam logic [2:0] S_POW_M = 3'd4;
   localparam logic [2:0] S_POW_S = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] aux_ff, aux_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic [31:0] last_result_ff, last_result_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_result_ff, rsp_result_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic [31:0] opa_u, opb_u, mag_a, mag_b;
   logic [31:0] mul_y;
   logic [63:0] mul_p;
   logic [32:0] sub_x, sub_y;
   logic [33:0] sub_d;
   logic        sub_ge;
   logic [31:0] sqrt_t;
   logic [31:0] e_next;
   logic        accept;
   logic        emit, keep_last;
   ica_pkg::alu_out_type emit_out;

   assign accept = start && !busy;
   assign opa_u  = req_operand_a;
   assign opb_u  = req_operand_b;
   assign mag_a  = opa_u[31] ? (32'd0 - opa_u) : opa_u;
   assign mag_b  = opb_u[31] ? (32'd0 - opb_u) : opb_u;

   // shared multiplier
   assign mul_y = (state_ff == S_POW_S) ? rem_ff : quo_ff;
   assign mul_p = 64'(rem_ff) * 64'(mul_y);

   // shared subtractor
   assign sqrt_t = quo_ff + aux_ff;
   assign sub_x  = (state_ff == S_DIV) ? {rem_ff, quo_ff[31]} : {1'b0, rem_ff};
   assign sub_y  = (state_ff == S_DIV) ? {1'b0, aux_ff} : {1'b0, sqrt_t};
   assign sub_d  = {1'b0, sub_x} - {1'b0, sub_y};
   assign sub_ge = !sub_d[33];
   assign e_next = aux_ff >> 1;

   always_comb begin
      state_in       = state_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      aux_in         = aux_ff;
      cnt_in         = cnt_ff;
      neg_in         = neg_ff;
      emit           = 1'b0;
      keep_last      = 1'b0;
      emit_out       = '{result: 32'd0, status: ica_pkg::STATUS_OK};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  ica_pkg::FUNC_ADD: begin
                     emit     = 1'b1;
                     emit_out = ica_pkg::sat33({opa_u[31], opa_u} + {opb_u[31], opb_u});
                  end
                  ica_pkg::FUNC_SUB: begin
                     emit     = 1'b1;
                     emit_out = ica_pkg::sat33({opa_u[31], opa_u} - {opb_u[31], opb_u});
                  end
                  ica_pkg::FUNC_ABS: begin
                     emit     = 1'b1;
                     emit_out = ica_pkg::sat33({1'b0, mag_a});
                  end
                  ica_pkg::FUNC_MUL: begin
                     rem_in   = mag_a;
                     quo_in   = mag_b;
                     neg_in   = opa_u[31] ^ opb_u[31];
                     state_in = S_MUL;
                  end
                  ica_pkg::FUNC_DIV: begin
                     if (opb_u == 32'd0) begin
                        emit     = 1'b1;
                        emit_out = '{result: 32'd0, status: ica_pkg::STATUS_ERR};
                     end else begin
                        rem_in   = 32'd0;
                        quo_in   = mag_a;
                        aux_in   = mag_b;
                        cnt_in   = 5'd0;
                        neg_in   = opa_u[31] ^ opb_u[31];
                        state_in = S_DIV;
                     end
                  end
                  ica_pkg::FUNC_POW: begin
                     priority if (opb_u[31]) begin
                        emit = 1'b1;
                        priority if (opa_u == 32'd0) begin
                           emit_out = '{result: 32'd0, status: ica_pkg::STATUS_ERR};
                        end else if (opa_u == 32'd1) begin
                           emit_out = '{result: 32'd1, status: ica_pkg::STATUS_OK};
                        end else if (opa_u == 32'hFFFF_FFFF) begin
                           emit_out = '{result: (opb_u[0] ? 32'hFFFF_FFFF : 32'd1),
                                        status: ica_pkg::STATUS_OK};
                        end else begin
                           emit_out = '{result: 32'd0, status: ica_pkg::STATUS_OK};
                        end
                     end else if (opb_u == 32'd0) begin
                        emit     = 1'b1;
                        emit_out = '{result: 32'd1, status: ica_pkg::STATUS_OK};
                     end else begin
                        rem_in   = mag_a;
                        quo_in   = 32'd1;
                        aux_in   = opb_u;
                        neg_in   = opa_u[31] & opb_u[0];
                        state_in = opb_u[0] ? S_POW_M : S_POW_S;
                     end
                  end
                  ica_pkg::FUNC_SQRT: begin
                     if (opa_u[31]) begin
                        emit     = 1'b1;
                        emit_out = '{result: 32'd0, status: ica_pkg::STATUS_ERR};
                     end else begin
                        rem_in   = opa_u;
                        quo_in   = 32'd0;
                        aux_in   = ica_pkg::SQRT_FIRST;
                        neg_in   = 1'b0;
                        state_in = S_SQRT;
                     end
                  end
                  default: begin
                     emit      = 1'b1;
                     keep_last = 1'b1;
                     emit_out  = '{result: last_result_ff, status: ica_pkg::STATUS_INV};
                  end
               endcase
            end
         end
         S_MUL: begin
            emit     = 1'b1;
            emit_out = ica_pkg::sat_mag(neg_ff, mul_p);
            state_in = S_IDLE;
         end
         S_DIV: begin
            if (sub_ge) begin
               rem_in = sub_d[31:0];
            end else begin
               rem_in = {rem_ff[30:0], quo_ff[31]};
            end
            quo_in = {quo_ff[30:0], sub_ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = S_FIN;
            end
         end
         S_SQRT: begin
            if (sub_ge) begin
               rem_in = sub_d[31:0];
               quo_in = (quo_ff >> 1) + aux_ff;
            end else begin
               quo_in = quo_ff >> 1;
            end
            aux_in = aux_ff >> 2;
            if (aux_ff[0]) begin
               state_in = S_FIN;
            end
         end
         S_POW_M: begin
            quo_in   = ica_pkg::pow_cap(mul_p);
            state_in = S_POW_S;
         end
         S_POW_S: begin
            aux_in = e_next;
            if (e_next != 32'd0) begin
               rem_in   = ica_pkg::pow_cap(mul_p);
               state_in = e_next[0] ? S_POW_M : S_POW_S;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            emit     = 1'b1;
            emit_out = ica_pkg::sat_mag(neg_ff, {32'd0, quo_ff});
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (emit) begin
         state_in = S_IDLE;
      end
   end

   always_comb begin
      rsp_valid_in   = emit;
      rsp_result_in  = emit ? emit_out.result : rsp_result_ff;
      rsp_status_in  = emit ? emit_out.status : rsp_status_ff;
      last_result_in = (emit && !keep_last) ? emit_out.result : last_result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         last_result_ff <= 32'd0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         last_result_ff <= last_result_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      aux_ff        <= aux_in;
      cnt_ff        <= cnt_in;
      neg_ff        <= neg_in;
      rsp_result_ff <= rsp_result_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_status = rsp_status_ff;

   `ICA_ASSERT_NOW(a_strobe_when_idle, clock, reset, rsp_valid, !busy)
   `ICA_ASSERT_NOW(a_result_tracks_last, clock, reset, rsp_valid, rsp_result_ff == last_result_ff)
   `ICA_ASSERT_NEXT(a_add_one_cycle, clock, reset, accept && (req_func == ica_pkg::FUNC_ADD), rsp_valid && !busy)
   `ICA_ASSERT_NEXT(a_div_runs, clock, reset, accept && (req_func == ica_pkg::FUNC_DIV) && (req_operand_b != 32'sd0), busy && !rsp_valid)

endmodule
